// File: rtl/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_BITS    = 7;
  localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int AGE_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_RESET   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [AGE_BITS-1:0]           age_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic [CFG_BITS-1:0]           cfg_t;

  typedef struct packed {
    smp_t val;
    age_t age;
  } entry_t;

  typedef struct packed {
    logic step;
    logic full;
    age_t last_age;
    smp_t key;
  } cell_ctrl_t;

endpackage

// File: rtl/swm_cell.sv
// One slot of the sorted window: holds a sample and its age, shifts with neighbors.
module swm_cell (
  input  logic                clk,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                rem_le,
  input  logic                rem_l,
  input  logic                below_left,
  input  logic                ltk_right,
  input  swm_pkg::entry_t     left,
  input  swm_pkg::entry_t     right,
  output swm_pkg::entry_t     ent,
  output logic                rm,
  output logic                ltk,
  output logic                below
);

  swm_pkg::entry_t ent_next;
  swm_pkg::entry_t src;

  assign rm    = ctrl.full && valid && (ent.age == ctrl.last_age);
  assign ltk   = valid && ($signed(ent.val) <= $signed(ctrl.key));
  assign below = rem_le ? ltk_right : ltk;

  always_comb begin
    src = ent;
    if (below) begin
      src = rem_le ? right : ent;
    end else if (!below_left) begin
      src = rem_l ? ent : left;
    end
    ent_next.val = src.val;
    ent_next.age = src.age + swm_pkg::age_t'(1);
    if (!below && below_left) begin
      ent_next.val = ctrl.key;
      ent_next.age = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      ent <= ent_next;
    end
  end

endmodule

// File: rtl/sliding_window_median_top.sv
// Running median filter: a sorted chain of cells with one output register.
// Each accepted sample updates the cell chain; its median is then registered.
// Throughput: one sample per cycle while in_ready is high; all cells update
// in parallel each beat, the median is read from the chain's middle cell.
// Reset (rst, synchronous): window length 3, window empty, no output pending.
// A write of window_len empties the window; cfg_ready is always high.
module sliding_window_median_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swm_pkg::smp_t       sample,
  output logic                out_valid,
  input  logic                out_ready,
  output swm_pkg::smp_t       median,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  swm_pkg::cfg_t       window_len
);

  localparam int N = swm_pkg::MAX_WINDOW;

  swm_pkg::cfg_t       len_reg;
  swm_pkg::len_t       fill;
  swm_pkg::len_t       fill_next;
  swm_pkg::len_t       len_eff;
  swm_pkg::age_t       mid;
  logic                full;
  logic                pend;
  logic                adv;
  logic                accept;
  swm_pkg::cell_ctrl_t ctrl;
  swm_pkg::entry_t     ent   [N];
  logic [N-1:0]        rm;
  logic [N-1:0]        ltk;
  logic [N-1:0]        below;
  logic [N-1:0]        valid;
  logic [N-1:0]        rem_le;
  logic [N-1:0]        rem_l;

  always_comb begin
    if (len_reg == '0) begin
      len_eff = swm_pkg::len_t'(1);
    end else if (swm_pkg::len_t'(len_reg) > swm_pkg::len_t'(N)) begin
      len_eff = swm_pkg::len_t'(N);
    end else begin
      len_eff = swm_pkg::len_t'(len_reg);
    end
  end

  assign mid       = swm_pkg::age_t'((len_eff - swm_pkg::len_t'(1)) >> 1);
  assign full      = (fill >= len_eff);
  assign fill_next = full ? fill : fill + swm_pkg::len_t'(1);

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv || !pend;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign ctrl.step     = accept;
  assign ctrl.full     = full;
  assign ctrl.last_age = swm_pkg::age_t'(len_eff - swm_pkg::len_t'(1));
  assign ctrl.key      = sample;

  // rm is one-hot or zero; cells at or above the removed one see rem_le.
  assign rem_le = ~(rm - N'(1));
  assign rem_l  = {rem_le[N-2:0], 1'b0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_pkg::entry_t left_ent;
    swm_pkg::entry_t right_ent;
    logic            below_l;
    logic            ltk_r;

    assign valid[i] = (fill > swm_pkg::len_t'(i));

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign below_l  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign below_l  = below[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_ent = '0;
      assign ltk_r     = 1'b0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
      assign ltk_r     = ltk[i+1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid[i]),
      .rem_le     (rem_le[i]),
      .rem_l      (rem_l[i]),
      .below_left (below_l),
      .ltk_right  (ltk_r),
      .left       (left_ent),
      .right      (right_ent),
      .ent        (ent[i]),
      .rm         (rm[i]),
      .ltk        (ltk[i]),
      .below      (below[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg   <= swm_pkg::cfg_t'(swm_pkg::LEN_RESET);
      fill      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_reg <= window_len;
        fill    <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        pend <= (fill_next >= len_eff);
      end else if (adv) begin
        pend <= 1'b0;
      end
      if (adv) begin
        out_valid <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pend) begin
      median <= ent[mid].val;
    end
  end

endmodule

// File: bench/sliding_window_median_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window median filter top level.
module sliding_window_median_top_test;

  typedef enum logic {BEAT_SAMPLE, BEAT_LENGTH} beat_kind_t;

  typedef struct {
    beat_kind_t    kind;
    swm_pkg::cfg_t len;
    swm_pkg::smp_t value;
  } beat_t;

  localparam swm_pkg::smp_t SMP_MIN = {1'b1, {(swm_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam swm_pkg::smp_t SMP_MAX = {1'b0, {(swm_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam int DRAIN_CYCLES = 6;
  localparam int CALM_TAIL    = 150;
  localparam int HOLD_AFTER   = 200;
  localparam int HOLD_CYCLES  = 200;
  localparam int TARGET_ITEMS = 1450;

  logic          clk        = 1'b0;
  logic          rst        = 1'b1;
  logic          in_valid   = 1'b0;
  logic          in_ready;
  swm_pkg::smp_t sample     = '0;
  logic          out_valid;
  logic          out_ready  = 1'b0;
  swm_pkg::smp_t median;
  logic          cfg_valid  = 1'b0;
  logic          cfg_ready;
  swm_pkg::cfg_t window_len = '0;

  beat_t         pending_beats[$];
  swm_pkg::smp_t expected_medians[$];
  swm_pkg::smp_t window_hist[$];
  swm_pkg::cfg_t cur_len = swm_pkg::cfg_t'(swm_pkg::LEN_RESET);

  int unsigned samples_in, medians_predicted, medians_checked, lengths_written;
  int unsigned errors;
  int unsigned gap_left, quiet_cycles, stall_left, hold_left;
  bit          hold_done;

  sliding_window_median_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .median     (median),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .window_len (window_len)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input swm_pkg::smp_t got,
                                 input swm_pkg::smp_t want);
    errors++;
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  // Slide the window by one sample; when full, queue its lower median.
  task automatic track_window(input swm_pkg::smp_t s);
    int unsigned   len;
    int            j;
    swm_pkg::smp_t srt [swm_pkg::MAX_WINDOW];
    swm_pkg::smp_t t;
    len = (cur_len == 0) ? 1 :
          ((cur_len > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : cur_len);
    window_hist.insert(window_hist.size(), s);
    if (window_hist.size() > len) window_hist.delete(0);
    if (window_hist.size() == len) begin
      for (int i = 0; i < len; i++) begin
        t = window_hist[i];
        j = i;
        while (j > 0 && srt[j-1] > t) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = t;
      end
      expected_medians.insert(expected_medians.size(), srt[(len - 1) / 2]);
      medians_predicted++;
    end
  endtask

  task automatic add_sample(input swm_pkg::smp_t v);
    beat_t b;
    b.kind  = BEAT_SAMPLE;
    b.len   = '0;
    b.value = v;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic add_length(input swm_pkg::cfg_t l);
    beat_t b;
    b.kind  = BEAT_LENGTH;
    b.len   = l;
    b.value = '0;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // Driver
  always @(posedge clk) begin
    beat_t head;
    logic  nxt_in, nxt_cfg;
    if (in_valid && in_ready || expected_medians.size() != 0) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
      nxt_in  = 1'b0;
      nxt_cfg = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_beats.size() != 0) begin
        head = pending_beats[0];
        if (head.kind == BEAT_LENGTH) begin
          if (quiet_cycles >= DRAIN_CYCLES && !in_valid) begin
            nxt_cfg = 1'b1;
            window_len <= head.len;
            pending_beats.delete(0);
          end
        end else begin
          nxt_in = 1'b1;
          sample <= head.value;
          pending_beats.delete(0);
          if (pending_beats.size() >= CALM_TAIL && hold_left == 0 &&
              $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 12);
        end
      end
      in_valid  <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // Long receiver hold-off so the pipeline backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && medians_predicted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor, checker and predictor
  always @(posedge clk) begin
    swm_pkg::smp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("unexpected median beat", median, '0);
        end else begin
          want = expected_medians.pop_front();
          medians_checked++;
          if (median !== want) report_mismatch("median", median, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        cur_len = window_len;
        window_hist.delete();
        lengths_written++;
      end
      if (in_valid && in_ready) begin
        samples_in++;
        track_window(sample);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (pending_beats.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    swm_pkg::smp_t v;
    swm_pkg::cfg_t l;
    int unsigned   total, eff, count, style, step;
    swm_pkg::cfg_t sweep[$];

    // reset length: extremes, sign change, duplicates
    add_sample(SMP_MIN);
    add_sample(SMP_MAX);
    add_sample(0);
    add_sample(-1);
    add_sample(1);
    add_sample(5);
    add_sample(5);
    add_sample(5);
    add_sample(-7);
    // length one: each sample is its own median
    add_length(1);
    add_sample(SMP_MAX);
    add_sample(SMP_MIN);
    add_sample(2);
    // length zero acts as one
    add_length(0);
    add_sample(-3);
    add_sample(4);
    // even length: lower middle value
    add_length(2);
    add_sample(10);
    add_sample(-10);
    add_sample(10);
    add_sample(SMP_MIN);
    add_sample(SMP_MAX);
    total = 19;

    sweep = '{7'd64, 7'd127, 7'd65, 7'd4, 7'd63, 7'd32, 7'd2, 7'd1, 7'd0, 7'd3};
    step = 0;
    while (total < TARGET_ITEMS) begin
      if (step < sweep.size()) l = sweep[step];
      else if ($urandom_range(0, 3) == 0) l = swm_pkg::cfg_t'($urandom_range(0, 127));
      else l = swm_pkg::cfg_t'($urandom_range(1, 16));
      step++;
      add_length(l);
      eff = (l == 0) ? 1 : ((l > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : l);
      count = eff + $urandom_range(10, 90);
      style = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) begin
        case (style)
          0: v = $urandom;
          1: begin
            v = $urandom_range(0, 8);
            v = v - 4;
          end
          2: begin
            case ($urandom_range(0, 3))
              0: v = SMP_MIN;
              1: v = SMP_MAX;
              2: v = 0;
              default: v = -1;
            endcase
          end
          default: begin
            if ($urandom_range(0, 1) == 0) v = $urandom;
            else v = $urandom_range(0, 20);
          end
        endcase
        add_sample(v);
      end
      total += count;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid || cfg_valid ||
           expected_medians.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples over %0d window length writes", samples_in,
             lengths_written);
    $display("%0d medians checked, %0d mismatches", medians_checked, errors);
    if (errors == 0) begin
      $display("sliding_window_median_top_test passed");
    end else begin
      $display("sliding_window_median_top_test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for median beats");
    $display("sliding_window_median_top_test failed");
    $finish;
  end

endmodule
